// ===== rtl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Word and pointer widths, command and status codes, control/status structs.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic take;   // capture the incoming command
    logic exec;   // run the queue access
    logic load;   // move the result into the output register
  } deq_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being emptied this cycle
  } deq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/deq_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_req_if: command channel
// valid/ready handshake carrying one queue command and its push word.
// ----------------------------------------------------------------------------
interface deq_req_if
  import deq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_rsp_if: result channel
// valid/ready handshake carrying the popped word, status and empty flag.
// ----------------------------------------------------------------------------
interface deq_rsp_if
  import deq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped_word;
  logic [1:0]               status;
  logic                     now_empty;

  modport source (output valid, output popped_word, output status, output now_empty,
                  input ready);
  modport sink   (input valid, input popped_word, input status, input now_empty,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl: sequencing state machine
// Steps each command through capture, access and result hand-off.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire deq_stat_t stat_i,
  output deq_ctl_t       ctl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACCESS = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.take = 1'b1;
          state_d    = S_ACCESS;
        end
      end
      S_ACCESS: begin
        ctl_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          ctl_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/deq_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_dpath: ring buffer datapath
// Entry memory, front/back pointers, occupancy and the result register.
// ----------------------------------------------------------------------------
module deq_dpath import deq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire deq_ctl_t                 ctl_i,
  output deq_stat_t                     stat_o,
  input  wire logic [1:0]               cmd_i,
  input  wire logic signed [WORD_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [WORD_W-1:0]      popped_word_o,
  output logic [1:0]                    status_o,
  output logic                          now_empty_o
);

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem_q [DEPTH];

  logic [1:0]        cmd_q;
  logic [WORD_W-1:0] word_q;
  logic [ADDR_W-1:0] front_q, front_d, back_q, back_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [WORD_W-1:0] rd_q;
  logic              pop_ok_q, pop_ok_d;
  logic [1:0]        st_q, st_d;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic [1:0]        out_st_q;
  logic              out_empty_q;

  logic [ADDR_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              wr_en, rd_en, empty, full;

  assign front_inc = (front_q == ADDR_LAST) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? ADDR_LAST : front_q - 1'b1;
  assign back_inc  = (back_q == ADDR_LAST) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? ADDR_LAST : back_q - 1'b1;
  assign empty     = (occ_q == '0);
  assign full      = (occ_q == CNT_FULL);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    occ_d    = occ_q;
    pop_ok_d = 1'b0;
    st_d     = ST_DONE;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = back_q;
    rd_addr  = front_q;
    case (cmd_q)
      CMD_PUSH_FRONT: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = front_dec;
          front_d = front_dec;
          occ_d   = occ_q + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = back_q;
          back_d  = back_inc;
          occ_d   = occ_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          rd_addr  = front_q;
          front_d  = front_inc;
          occ_d    = occ_q - 1'b1;
        end
      end
      default: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          rd_addr  = back_dec;
          back_d   = back_dec;
          occ_d    = occ_q - 1'b1;
        end
      end
    endcase
  end

  // entry memory: one write or one registered read per access
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && wr_en) begin
      mem_q[wr_addr] <= word_q;
    end
    if (ctl_i.exec && rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // captured command and per-access flags (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cmd_q  <= cmd_i;
      word_q <= value_i;
    end
    if (ctl_i.exec) begin
      st_q <= st_d;
    end
    if (ctl_i.load) begin
      out_word_q  <= pop_ok_q ? rd_q : ALL_ONES;
      out_st_q    <= st_q;
      out_empty_q <= empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      occ_q       <= '0;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.exec) begin
        front_q  <= front_d;
        back_q   <= back_d;
        occ_q    <= occ_d;
        pop_ok_q <= pop_ok_d;
      end
      if (ctl_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign popped_word_o   = out_word_q;
  assign status_o        = out_st_q;
  assign now_empty_o     = out_empty_q;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words on a ring buffer
// Push/pop at either end; every command returns one result transfer.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+-------------
//  req_i    | in  | cmd[1:0], value[31:0] signed         | valid/ready
//  rsp_o    | out | popped_word[31:0], status, now_empty | valid/ready
//
//  Sequence: a command steps the sequencer through capture, memory access
//  with registered read and result load; the result becomes valid when it
//  is loaded into the output register. One command is in flight at a time,
//  so the next command is taken only once the last result has been loaded.
//  Reset: pointers, occupancy and handshake state clear; entries are not
//  cleared and are only ever read after being written.
//  Stalls: the output register frees req_i to take the next command while a
//  result waits; the sequencer holds in its final step only if that result
//  is still not taken.
//
module double_ended_queue import deq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  deq_ctl_t  ctl;
  deq_stat_t stat;

  // sequencer: capture -> access -> load result
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // ring buffer, pointers and result register
  deq_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .cmd_i         (req_i.cmd),
    .value_i       (req_i.value),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .popped_word_o (rsp_o.popped_word),
    .status_o      (rsp_o.status),
    .now_empty_o   (rsp_o.now_empty)
  );

  // one command in flight: ready drops right after a transfer in
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("command accepted while another is in flight");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !ctl.load)
    else $error("result register overwritten before transfer");

  // a refused pop means the queue is empty; a refused push means it is not
  a_status_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_EMPTY) |-> rsp_o.now_empty)
    else $error("empty status with non-empty queue");

  a_status_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |-> !rsp_o.now_empty)
    else $error("full status with empty queue");

  // a new result appears only after a load
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(ctl.load))
    else $error("result valid without load");

endmodule

`default_nettype wire
